FILE: rtl/core/bsspd_pkg.sv
// ----------------------------------------------------------------------------
// bsspd_pkg
// shared types, constants and the control store of the buck duty controller
// ----------------------------------------------------------------------------
`default_nettype none

package bsspd_pkg;

  // field and register widths
  localparam int ADC_W   = 12;
  localparam int CNT_W   = 12;
  localparam int VSET_W  = 19;
  localparam int GP_W    = 18;
  localparam int GI_W    = 16;
  localparam int LIM_W   = 17;
  localparam int DUTY_W  = 17;
  localparam int INT_W   = 18;

  // adc code to q16 volts scale, q24
  localparam int SCALE_W = 24;
  localparam logic [SCALE_W-1:0] ADC_VOLT_SCALE_Q24 = 24'd19335;

  // datapath widths
  localparam int VOUT_W  = ADC_W + SCALE_W - 8;
  localparam int ERR_W   = VOUT_W + 1;
  localparam int MB_W    = SCALE_W + 1;
  localparam int PROD_W  = ERR_W + MB_W;
  localparam int RND_W   = PROD_W - 16;
  localparam int SUM_W   = RND_W + 1;

  // apb port
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ADC  = 1'b1;

  // register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_RAMP_STEP   = 3'd0,
    REG_RAMP_TARGET = 3'd1,
    REG_PERIOD      = 3'd2,
    REG_VSET        = 3'd3,
    REG_GAIN_P      = 3'd4,
    REG_GAIN_I      = 3'd5,
    REG_INT_LIMIT   = 3'd6,
    REG_DUTY_CEIL   = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [CNT_W-1:0]  RST_RAMP_STEP   = 12'd2;
  localparam logic [CNT_W-1:0]  RST_RAMP_TARGET = 12'd92;
  localparam logic [CNT_W-1:0]  RST_PERIOD      = 12'd333;
  localparam logic [VSET_W-1:0] RST_VSET        = 19'd216269;
  localparam logic [GP_W-1:0]   RST_GAIN_P      = 18'd19661;
  localparam logic [GI_W-1:0]   RST_GAIN_I      = 16'd983;
  localparam logic [LIM_W-1:0]  RST_INT_LIMIT   = 17'd52429;
  localparam logic [DUTY_W-1:0] RST_DUTY_CEIL   = 17'd58982;

  typedef struct packed {
    logic [CNT_W-1:0]  ramp_step;
    logic [CNT_W-1:0]  ramp_target;
    logic [CNT_W-1:0]  period_counts;
    logic [VSET_W-1:0] voltage_setpoint;
    logic [GP_W-1:0]   gain_proportional;
    logic [GI_W-1:0]   gain_integral;
    logic [LIM_W-1:0]  integrator_limit;
    logic [DUTY_W-1:0] duty_ceiling;
  } cfg_t;

  // microcode
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_VOLT,
    OP_ERR,
    OP_MUL_GI,
    OP_INTEG,
    OP_MUL_GP,
    OP_DUTY,
    OP_MUL_PER,
    OP_CMP,
    OP_RAMP
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_QUIET,
    COND_TICK
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            emit;
    logic            fin;
  } ucode_t;

  localparam logic [PC_W-1:0] STEP_ENTRY = 4'd0;
  localparam logic [PC_W-1:0] STEP_RAMP  = 4'd10;
  localparam logic [PC_W-1:0] STEP_QUIET = 4'd11;

  function automatic ucode_t bsspd_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '{op: OP_NOP, cond: COND_NONE, target: STEP_ENTRY, emit: 1'b0, fin: 1'b0};
    case (pc)
      4'd0:  begin uc.cond = COND_QUIET; uc.target = STEP_QUIET; end
      4'd1:  begin uc.cond = COND_TICK;  uc.target = STEP_RAMP;  end
      4'd2:  uc.op = OP_MUL_VOLT;
      4'd3:  uc.op = OP_ERR;
      4'd4:  uc.op = OP_MUL_GI;
      4'd5:  uc.op = OP_INTEG;
      4'd6:  uc.op = OP_MUL_GP;
      4'd7:  uc.op = OP_DUTY;
      4'd8:  uc.op = OP_MUL_PER;
      4'd9:  begin uc.op = OP_CMP;  uc.emit = 1'b1; uc.fin = 1'b1; end
      4'd10: begin uc.op = OP_RAMP; uc.emit = 1'b1; uc.fin = 1'b1; end
      default: uc.fin = 1'b1;
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bsspd_ifs.sv
// ----------------------------------------------------------------------------
// bsspd channel interfaces
// valid/ready channels for controller items and compare results
// ----------------------------------------------------------------------------
`default_nettype none

interface bsspd_ctl_if;
  import bsspd_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ADC_W-1:0] adc_code;
  modport source (output valid, kind, adc_code, input ready);
  modport sink   (input valid, kind, adc_code, output ready);
endinterface

interface bsspd_pwm_if;
  import bsspd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] compare_value;
  logic             soft_start_done;
  modport source (output valid, compare_value, soft_start_done, input ready);
  modport sink   (input valid, compare_value, soft_start_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bsspd_regs.sv
// ----------------------------------------------------------------------------
// bsspd_regs
// apb configuration registers of the buck duty controller
// ----------------------------------------------------------------------------
`default_nettype none

module bsspd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bsspd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bsspd_pkg::DATA_W-1:0] pwdata,
  output      logic [bsspd_pkg::DATA_W-1:0] prdata,
  output      logic                        pready,
  output      bsspd_pkg::cfg_t             cfg
);
  import bsspd_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step         <= RST_RAMP_STEP;
      cfg.ramp_target       <= RST_RAMP_TARGET;
      cfg.period_counts     <= RST_PERIOD;
      cfg.voltage_setpoint  <= RST_VSET;
      cfg.gain_proportional <= RST_GAIN_P;
      cfg.gain_integral     <= RST_GAIN_I;
      cfg.integrator_limit  <= RST_INT_LIMIT;
      cfg.duty_ceiling      <= RST_DUTY_CEIL;
    end else if (wr) begin
      case (idx)
        REG_RAMP_STEP:   cfg.ramp_step         <= pwdata[CNT_W-1:0];
        REG_RAMP_TARGET: cfg.ramp_target       <= pwdata[CNT_W-1:0];
        REG_PERIOD:      cfg.period_counts     <= pwdata[CNT_W-1:0];
        REG_VSET:        cfg.voltage_setpoint  <= pwdata[VSET_W-1:0];
        REG_GAIN_P:      cfg.gain_proportional <= pwdata[GP_W-1:0];
        REG_GAIN_I:      cfg.gain_integral     <= pwdata[GI_W-1:0];
        REG_INT_LIMIT:   cfg.integrator_limit  <= pwdata[LIM_W-1:0];
        REG_DUTY_CEIL:   cfg.duty_ceiling      <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RAMP_STEP:   prdata = DATA_W'(cfg.ramp_step);
      REG_RAMP_TARGET: prdata = DATA_W'(cfg.ramp_target);
      REG_PERIOD:      prdata = DATA_W'(cfg.period_counts);
      REG_VSET:        prdata = DATA_W'(cfg.voltage_setpoint);
      REG_GAIN_P:      prdata = DATA_W'(cfg.gain_proportional);
      REG_GAIN_I:      prdata = DATA_W'(cfg.gain_integral);
      REG_INT_LIMIT:   prdata = DATA_W'(cfg.integrator_limit);
      REG_DUTY_CEIL:   prdata = DATA_W'(cfg.duty_ceiling);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/buck_softstart_pi_duty.sv
// ----------------------------------------------------------------------------
// buck_softstart_pi_duty
// soft start ramp and pi duty controller producing pwm compare values
// ----------------------------------------------------------------------------
// an adc item runs every step up to the compare, a ramp tick the entry, tick
//   test and ramp steps, an item without a result the entry and quiet steps;
//   the next item is taken the cycle after the last step
// the microcode program walks one step per cycle over a single multiplier,
//   but a waiting result stalls only the step that emits the next one
// reset (synchronous, active high): registers to defaults, ramp at zero,
//   soft start running, integrator cleared, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module buck_softstart_pi_duty (
  input  wire logic                        clk,
  input  wire logic                        rst,
  bsspd_ctl_if.sink                        ctl,
  bsspd_pwm_if.source                      pwm,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bsspd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bsspd_pkg::DATA_W-1:0] pwdata,
  output      logic [bsspd_pkg::DATA_W-1:0] prdata,
  output      logic                        pready
);
  import bsspd_pkg::*;

  cfg_t cfg;

  bsspd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------- sequencer
  logic             busy;
  logic [PC_W-1:0]  pc;
  logic             kind;       // latched item
  logic [ADC_W-1:0] adc;
  ucode_t           uc;
  logic             cond_hit;
  logic             stall;      // emitting step blocked by a waiting result
  logic             exec;

  // controller state
  logic [CNT_W-1:0]       ramp_compare;
  logic                   ramp_finished;
  logic signed [INT_W-1:0] integrator;

  // datapath registers
  logic signed [PROD_W-1:0] prod;
  logic signed [ERR_W-1:0]  err;
  logic [DUTY_W-1:0]        duty;

  // output register
  logic             out_valid;
  logic [CNT_W-1:0] out_compare;
  logic             out_done;

  // no item is taken while reset is held
  assign ctl.ready           = !busy && !rst;
  assign pwm.valid           = out_valid;
  assign pwm.compare_value   = out_compare;
  assign pwm.soft_start_done = out_done;

  assign uc    = bsspd_rom(pc);
  assign stall = uc.emit && out_valid && !pwm.ready;
  assign exec  = busy && !stall;

  always_comb begin
    case (uc.cond)
      // items that leave no result: tick after soft start, sample during it
      COND_QUIET: cond_hit = (kind == KIND_TICK) ? ramp_finished : !ramp_finished;
      COND_TICK:  cond_hit = (kind == KIND_TICK);
      default:    cond_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= STEP_ENTRY;
    end else if (!busy) begin
      if (ctl.valid) begin
        busy <= 1'b1;
        pc   <= STEP_ENTRY;
      end
    end else if (exec) begin
      if (uc.fin) begin
        busy <= 1'b0;
      end else if (cond_hit) begin
        pc <= uc.target;
      end else begin
        pc <= pc + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && ctl.valid) begin
      kind <= ctl.kind;
      adc  <= ctl.adc_code;
    end
  end

  // ----------------------------------------------------------------- datapath
  // shared multiplier, operands picked by the current op
  logic signed [ERR_W-1:0]  mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    case (uc.op)
      OP_MUL_VOLT: begin
        mul_a = ERR_W'(adc);
        mul_b = MB_W'(ADC_VOLT_SCALE_Q24);
      end
      OP_MUL_GI: begin
        mul_a = err;
        mul_b = MB_W'(cfg.gain_integral);
      end
      OP_MUL_GP: begin
        mul_a = err;
        mul_b = MB_W'(cfg.gain_proportional);
      end
      OP_MUL_PER: begin
        mul_a = ERR_W'(duty);
        mul_b = MB_W'(cfg.period_counts);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // vout = round(adc * scale / 2^8), err = setpoint - vout
  logic signed [PROD_W-1:0] vround;
  logic [VOUT_W-1:0]        vout;
  logic signed [ERR_W-1:0]  err_next;

  assign vround   = prod + PROD_W'(128);
  assign vout     = vround[8 +: VOUT_W];
  assign err_next = ERR_W'({1'b0, cfg.voltage_setpoint}) - ERR_W'({1'b0, vout});

  // q16 rounding: add one half, arithmetic shift (floor)
  logic signed [PROD_W-1:0] pround;
  logic signed [RND_W-1:0]  rnd;

  assign pround = prod + PROD_W'(32768);
  assign rnd    = pround[PROD_W-1:16];

  // integrator update with symmetric clamp
  logic signed [SUM_W-1:0] rnd_ext;
  logic signed [SUM_W-1:0] integ_ext;
  logic signed [SUM_W-1:0] lim_ext;
  logic signed [SUM_W-1:0] integ_sum;
  logic signed [INT_W-1:0] integ_next;

  assign rnd_ext   = SUM_W'(rnd);
  assign integ_ext = SUM_W'(integrator);
  assign lim_ext   = SUM_W'(cfg.integrator_limit);
  assign integ_sum = integ_ext + rnd_ext;

  always_comb begin
    if (integ_sum > lim_ext) begin
      integ_next = INT_W'(lim_ext);
    end else if (integ_sum < -lim_ext) begin
      integ_next = INT_W'(-lim_ext);
    end else begin
      integ_next = INT_W'(integ_sum);
    end
  end

  // duty = p term + integrator, clamped to 0..ceiling
  logic signed [SUM_W-1:0] ceil_ext;
  logic [DUTY_W-1:0]       duty_next;

  assign ceil_ext = SUM_W'(cfg.duty_ceiling);

  always_comb begin
    if (integ_sum < 0) begin
      duty_next = '0;
    end else if (integ_sum > ceil_ext) begin
      duty_next = cfg.duty_ceiling;
    end else begin
      duty_next = DUTY_W'(integ_sum);
    end
  end

  // compare = min(round(duty * period / 2^16), period)
  logic [CNT_W-1:0] cmp_next;

  always_comb begin
    if (rnd > RND_W'(cfg.period_counts)) begin
      cmp_next = cfg.period_counts;
    end else begin
      cmp_next = rnd[CNT_W-1:0];
    end
  end

  // soft start ramp
  logic [CNT_W:0]   ramp_sum;
  logic             ramp_hit;
  logic [CNT_W-1:0] ramp_next;

  assign ramp_sum  = {1'b0, ramp_compare} + {1'b0, cfg.ramp_step};
  assign ramp_hit  = ramp_sum >= {1'b0, cfg.ramp_target};
  assign ramp_next = ramp_hit ? cfg.ramp_target : ramp_sum[CNT_W-1:0];

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (exec) begin
      case (uc.op)
        OP_MUL_VOLT, OP_MUL_GI, OP_MUL_GP, OP_MUL_PER: prod <= mul_p;
        OP_ERR:  err  <= err_next;
        OP_DUTY: duty <= duty_next;
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_compare  <= '0;
      ramp_finished <= 1'b0;
      integrator    <= '0;
    end else if (exec) begin
      case (uc.op)
        OP_INTEG: integrator <= integ_next;
        OP_RAMP: begin
          ramp_compare <= ramp_next;
          if (ramp_hit) begin
            ramp_finished <= 1'b1;
            integrator    <= '0;    // pi starts from zero after the ramp
          end
        end
        default: ;
      endcase
    end
  end

  // output register, loads on the emitting step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec && uc.emit) begin
      out_valid <= 1'b1;
    end else if (pwm.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && uc.emit) begin
      case (uc.op)
        OP_RAMP: begin
          out_compare <= ramp_next;
          out_done    <= ramp_hit;
        end
        default: begin
          out_compare <= cmp_next;
          out_done    <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bsspd_checker.sv
// ----------------------------------------------------------------------------
// bsspd_checker
// port-level checks of the buck duty controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bsspd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic ctl_valid,
  input wire logic ctl_ready,
  input wire logic pwm_valid,
  input wire logic pwm_ready,
  input wire logic pwm_done
);

  logic done_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_seen <= 1'b0;
    end else if (pwm_valid && pwm_ready && pwm_done) begin
      done_seen <= 1'b1;
    end
  end

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && !pwm_ready |=> pwm_valid)
    else $error("result dropped while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    ctl_valid && ctl_ready |=> !ctl_ready)
    else $error("input accepted while busy");

  // a new result appears only while an item is in work
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(pwm_valid) |-> !$past(ctl_ready))
    else $error("result without an item in work");

  // soft start never restarts once done
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && done_seen |-> pwm_done)
    else $error("soft start done flag fell");

endmodule

bind buck_softstart_pi_duty bsspd_checker u_bsspd_checker (
  .clk       (clk),
  .rst       (rst),
  .ctl_valid (ctl.valid),
  .ctl_ready (ctl.ready),
  .pwm_valid (pwm.valid),
  .pwm_ready (pwm.ready),
  .pwm_done  (pwm.soft_start_done)
);

`default_nettype wire
